// ===== design/dorr_pkg.sv =====
// ----------------------------------------------------------------------------
// dorr_pkg
// Shared widths and codes for the drop-oldest packet receive ring.
// ----------------------------------------------------------------------------
package dorr_pkg;

   localparam int OP_W     = 2;
   localparam int LEN_W    = 16;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int ADDR_W   = 12;
   localparam int DROP_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_HEADER = 2'd0,
      OP_ID     = 2'd1,
      OP_DATA   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPT = 3'd0,
      ST_COMMIT = 3'd1,
      ST_LONG   = 3'd2,
      ST_ZERO   = 3'd3,
      ST_IGNORE = 3'd4
   } status_type;

endpackage

// ===== design/drop_oldest_packet_receive_ring.sv =====
// ----------------------------------------------------------------------------
// drop_oldest_packet_receive_ring
// Writer side of a packet ring: data words, per-packet id words and a
// descriptor (length) ring; old packets are dropped to make room.
// ----------------------------------------------------------------------------
// Timing: id and data items and rejected headers give a registered result
//   that strobes in the next cycle. A header that opens a packet keeps the
//   block busy while it drops packets to make data room; each such drop
//   needs one read of the length memory (one entry per cycle).
// Throughput: one word item per cycle while the block is not busy.
// Reset: synchronous, clears indexes, pointers and packet state; the stores
//   are not cleared and need no clearing pass. Results cannot be stalled.
module drop_oldest_packet_receive_ring #(
   parameter int DATA_DEPTH = 4096,
   parameter int DESC_DEPTH = 64,
   parameter int ID_WORDS   = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dorr_pkg::OP_W-1:0]      req_op,
   input  logic [dorr_pkg::LEN_W-1:0]     req_length,
   input  logic [dorr_pkg::WORD_W-1:0]    req_word,
   output logic                           rsp_valid,
   output logic [dorr_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dorr_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [dorr_pkg::ADDR_W-1:0]    rsp_start_address,
   output logic [dorr_pkg::DROP_W-1:0]    rsp_dropped
);
   import dorr_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);
   localparam int IW = $clog2(DESC_DEPTH);
   localparam int KW = $clog2(ID_WORDS + 1);
   localparam int MW = $clog2(DESC_DEPTH * ID_WORDS);
   localparam int CW = $clog2(DESC_DEPTH + 1);
   localparam logic [AW:0] DMAX  = (AW+1)'(DATA_DEPTH - 1);
   localparam logic [AW:0] DSIZE = (AW+1)'(DATA_DEPTH);

   typedef enum logic {S_IDLE, S_DROP} state_type;

   function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DSIZE) begin
         sum = sum - DSIZE;
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [IW-1:0] desc_next(input logic [IW-1:0] i);
      logic [IW-1:0] n;
      n = (i == IW'(DESC_DEPTH - 1)) ? '0 : i + 1'b1;
      return n;
   endfunction

   // memories
   logic [AW-1:0]     length_mem [DESC_DEPTH];
   logic [WORD_W-1:0] id_mem     [DESC_DEPTH * ID_WORDS];
   logic [WORD_W-1:0] data_mem   [DATA_DEPTH];

   state_type         state_ff, state_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     wr_idx_ff, wr_idx_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     pstart_ff, pstart_in;
   logic              open_ff, open_in;
   logic [KW-1:0]     ids_left_ff, ids_left_in;
   logic [AW-1:0]     data_left_ff, data_left_in;
   logic [AW-1:0]     len_q_ff, len_q_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0] rsp_start_ff, rsp_start_in;
   logic [DROP_W-1:0] rsp_dropped_ff, rsp_dropped_in;
   logic [AW-1:0]     len_rd_ff;

   logic              len_we, id_we, data_we;
   logic [KW-1:0]     id_k;
   logic [MW-1:0]     id_addr;
   logic [AW:0]       used_wide;
   logic [AW-1:0]     used;
   logic              need_room;
   logic              ring_full;
   logic              too_long;
   logic [AW-1:0]     wp_step;

   // words held in the ring between read and write pointers
   always_comb begin
      if (wp_ff >= rp_ff) begin
         used_wide = {1'b0, wp_ff} - {1'b0, rp_ff};
      end else begin
         used_wide = {1'b0, wp_ff} + DSIZE - {1'b0, rp_ff};
      end
   end
   assign used      = used_wide[AW-1:0];
   assign need_room = (({1'b0, used} + {1'b0, len_q_ff}) > DMAX) && (rd_idx_ff != wr_idx_ff);
   assign ring_full = (desc_next(wr_idx_ff) == rd_idx_ff);
   assign too_long  = {1'b0, req_length} > 17'(DATA_DEPTH - 1);
   assign id_k      = KW'(ID_WORDS) - ids_left_ff;
   assign id_addr   = MW'(32'(wr_idx_ff) * ID_WORDS + 32'(id_k));
   assign wp_step   = ptr_add(wp_ff, AW'(1));

   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      rp_in          = rp_ff;
      wp_in          = wp_ff;
      pstart_in      = pstart_ff;
      open_in        = open_ff;
      ids_left_in    = ids_left_ff;
      data_left_in   = data_left_ff;
      len_q_in       = len_q_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ST_IGNORE;
      rsp_slot_in    = '0;
      rsp_start_in   = '0;
      rsp_dropped_in = '0;
      len_we         = 1'b0;
      id_we          = 1'b0;
      data_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               unique case (op_type'(req_op))
                  OP_HEADER: begin
                     rsp_valid_in = 1'b0;
                     // abandon an unfinished packet
                     if (open_ff) begin
                        wp_in        = pstart_ff;
                        open_in      = 1'b0;
                        ids_left_in  = '0;
                        data_left_in = '0;
                     end
                     if (too_long) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_LONG;
                     end else if (req_length == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_ZERO;
                     end else begin
                        len_q_in = req_length[AW-1:0];
                        cnt_in   = '0;
                        state_in = S_DROP;
                     end
                  end
                  OP_ID: begin
                     if (open_ff && ids_left_ff != '0) begin
                        id_we         = 1'b1;
                        ids_left_in   = ids_left_ff - 1'b1;
                        rsp_status_in = ST_ACCEPT;
                        rsp_slot_in   = SLOT_W'(wr_idx_ff);
                        rsp_start_in  = ADDR_W'(pstart_ff);
                     end
                  end
                  OP_DATA: begin
                     if (open_ff && ids_left_ff == '0 && data_left_ff != '0) begin
                        data_we       = 1'b1;
                        wp_in         = wp_step;
                        data_left_in  = data_left_ff - 1'b1;
                        rsp_status_in = ST_ACCEPT;
                        rsp_slot_in   = SLOT_W'(wr_idx_ff);
                        rsp_start_in  = ADDR_W'(pstart_ff);
                        if (data_left_ff == AW'(1)) begin
                           len_we        = 1'b1;
                           wr_idx_in     = desc_next(wr_idx_ff);
                           open_in       = 1'b0;
                           rsp_status_in = ST_COMMIT;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_IGNORE;
                  end
               endcase
            end
         end
         S_DROP: begin
            if (need_room) begin
               rp_in     = ptr_add(rp_ff, len_rd_ff);
               rd_idx_in = desc_next(rd_idx_ff);
               cnt_in    = cnt_ff + 1'b1;
            end else begin
               // one more drop frees a descriptor slot
               if (ring_full) begin
                  rp_in     = ptr_add(rp_ff, len_rd_ff);
                  rd_idx_in = desc_next(rd_idx_ff);
               end
               pstart_in      = wp_ff;
               open_in        = 1'b1;
               ids_left_in    = KW'(ID_WORDS);
               data_left_in   = len_q_ff;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_ACCEPT;
               rsp_slot_in    = SLOT_W'(wr_idx_ff);
               rsp_start_in   = ADDR_W'(wp_ff);
               rsp_dropped_in = DROP_W'(cnt_ff + CW'(ring_full));
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         pstart_ff    <= '0;
         open_ff      <= 1'b0;
         ids_left_ff  <= '0;
         data_left_ff <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         pstart_ff    <= pstart_in;
         open_ff      <= open_in;
         ids_left_ff  <= ids_left_in;
         data_left_ff <= data_left_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_q_ff       <= len_q_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   // length ring: read address follows the next read index, so the data
   // always belongs to the current oldest descriptor
   always_ff @(posedge clock) begin
      if (len_we) begin
         length_mem[wr_idx_ff] <= len_q_ff;
      end
      len_rd_ff <= length_mem[rd_idx_in];
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_addr] <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[wp_ff] <= req_word;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_start_address = rsp_start_ff;
   assign rsp_dropped       = rsp_dropped_ff;

endmodule

// ===== design/dorr_chk.sv =====
// ----------------------------------------------------------------------------
// dorr_chk
// Port-level checks for the drop-oldest packet receive ring.
// ----------------------------------------------------------------------------
module dorr_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [dorr_pkg::STATUS_W-1:0]  rsp_status,
   input logic [dorr_pkg::SLOT_W-1:0]    rsp_slot,
   input logic [dorr_pkg::ADDR_W-1:0]    rsp_start_address,
   input logic [dorr_pkg::DROP_W-1:0]    rsp_dropped
);
   import dorr_pkg::*;

   // an accepted item either finishes at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item produced neither result nor busy");

   // a result only follows an accepted item or header work
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start && !busy)))
      else $error("result without a pending item");

   a_no_result_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while busy");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_LONG || rsp_status == ST_ZERO ||
                     rsp_status == ST_IGNORE))
      |-> (rsp_slot == '0 && rsp_start_address == '0 && rsp_dropped == '0))
      else $error("rejected item carries nonzero fields");

endmodule

bind drop_oldest_packet_receive_ring dorr_chk u_dorr_chk (.*);
